// ===== sv/texture_mip_chain_size_defines.svh =====
// ----------------------------------------------------------------------------
// texture_mip_chain_size_defines
// assertion macros for the mip chain size block
// ----------------------------------------------------------------------------
`ifndef TEXTURE_MIP_CHAIN_SIZE_DEFINES_SVH
`define TEXTURE_MIP_CHAIN_SIZE_DEFINES_SVH

`ifndef SYNTHESIS
`define TMCS_ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("texture_mip_chain_size: assertion failed");
`define TMCS_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("texture_mip_chain_size: reset assertion failed");
`else
`define TMCS_ASSERT_CLK(label, prop)
`define TMCS_ASSERT_RST(label, prop)
`endif

`endif

// ===== sv/tmcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcs_pkg
// types, constants and format table of the mip chain size block
// ----------------------------------------------------------------------------
package tmcs_pkg;

    localparam int FMT_W        = 7;
    localparam int DIM_W        = 15;
    localparam int DEP_W        = 12;
    localparam int MIP_W        = 4;
    localparam int TOT_W        = 32;
    localparam int BLK_W        = 4;
    localparam int BYTES_W      = 5;
    localparam int BD_W         = BYTES_W + DEP_W;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 40;

    localparam int DEF_MAX_MIP_LEVELS = 15;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [FMT_W-1:0] ASTC_LIN_BASE  = 7'd87;
    localparam logic [FMT_W-1:0] ASTC_SRGB_BASE = 7'd101;
    localparam logic [FMT_W-1:0] NUM_FORMATS    = 7'd115;

    // reciprocal constants for divide by 3 and by 5
    localparam int                DIV3_SH  = 17;
    localparam logic [DIV3_SH-1:0] DIV3_MUL = 17'd43691;
    localparam int                DIV5_SH  = 18;
    localparam logic [15:0]        DIV5_MUL = 16'd52429;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_3,
        DIV_5
    } t_div_kind;

    typedef struct packed {
        logic [1:0] shift;
        t_div_kind  kind;
    } t_div_sel;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [BLK_W-1:0]   bw;
        logic [BLK_W-1:0]   bh;
    } t_fmt;

    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [MIP_W-1:0] mips;
        logic [BD_W-1:0]  bd;
        logic [BLK_W-1:0] bw;
        logic [BLK_W-1:0] bh;
        t_div_sel         sel_x;
        t_div_sel         sel_y;
    } t_job;

    function automatic t_fmt fmt_lookup(logic [FMT_W-1:0] code);
        t_fmt             f;
        logic [FMT_W-1:0] idx;
        f   = '{bytes: 5'd0, bw: 4'd1, bh: 4'd1};
        idx = '0;
        priority if (code == 7'd0) f.bytes = 5'd0;
        else if (code < 7'd8)   f.bytes = 5'd1;
        else if (code < 7'd11)  f.bytes = 5'd2;
        else if (code < 7'd14)  f.bytes = 5'd4;
        else if (code < 7'd18)  f.bytes = 5'd2;
        else if (code < 7'd21)  f.bytes = 5'd4;
        else if (code < 7'd24)  f.bytes = 5'd8;
        else if (code < 7'd29)  f.bytes = 5'd3;
        else if (code < 7'd32)  f.bytes = 5'd6;
        else if (code < 7'd35)  f.bytes = 5'd12;
        else if (code < 7'd41)  f.bytes = 5'd4;
        else if (code < 7'd44)  f.bytes = 5'd8;
        else if (code < 7'd47)  f.bytes = 5'd16;
        else if (code == 7'd47) f.bytes = 5'd2;
        else if (code == 7'd48) f.bytes = 5'd4;
        else if (code < 7'd54)  f.bytes = 5'd2;
        else if (code == 7'd54) f.bytes = 5'd4;
        else if (code == 7'd55) f.bytes = 5'd5;
        else if (code < 7'd60)  f = '{bytes: 5'd8,  bw: 4'd4, bh: 4'd4};
        else if (code < 7'd64)  f = '{bytes: 5'd16, bw: 4'd4, bh: 4'd4};
        else if (code < 7'd66)  f = '{bytes: 5'd8,  bw: 4'd4, bh: 4'd4};
        else if (code < 7'd72)  f = '{bytes: 5'd16, bw: 4'd4, bh: 4'd4};
        else if (code < 7'd79)  f = '{bytes: 5'd8,  bw: 4'd4, bh: 4'd4};
        else if (code < 7'd81)  f = '{bytes: 5'd16, bw: 4'd4, bh: 4'd4};
        else if (code < 7'd83)  f = '{bytes: 5'd8,  bw: 4'd8, bh: 4'd4};
        else if (code < 7'd85)  f = '{bytes: 5'd8,  bw: 4'd4, bh: 4'd4};
        else if (code == 7'd85) f = '{bytes: 5'd8,  bw: 4'd8, bh: 4'd4};
        else if (code < ASTC_LIN_BASE) f = '{bytes: 5'd8, bw: 4'd4, bh: 4'd4};
        else if (code < NUM_FORMATS) begin
            idx = (code < ASTC_SRGB_BASE) ? (code - ASTC_LIN_BASE) : (code - ASTC_SRGB_BASE);
            f.bytes = 5'd16;
            case (idx[3:0])
                4'd0:    begin f.bw = 4'd4;  f.bh = 4'd4;  end
                4'd1:    begin f.bw = 4'd5;  f.bh = 4'd4;  end
                4'd2:    begin f.bw = 4'd5;  f.bh = 4'd5;  end
                4'd3:    begin f.bw = 4'd6;  f.bh = 4'd5;  end
                4'd4:    begin f.bw = 4'd6;  f.bh = 4'd6;  end
                4'd5:    begin f.bw = 4'd8;  f.bh = 4'd5;  end
                4'd6:    begin f.bw = 4'd8;  f.bh = 4'd6;  end
                4'd7:    begin f.bw = 4'd8;  f.bh = 4'd8;  end
                4'd8:    begin f.bw = 4'd10; f.bh = 4'd5;  end
                4'd9:    begin f.bw = 4'd10; f.bh = 4'd6;  end
                4'd10:   begin f.bw = 4'd10; f.bh = 4'd8;  end
                4'd11:   begin f.bw = 4'd10; f.bh = 4'd10; end
                4'd12:   begin f.bw = 4'd12; f.bh = 4'd10; end
                4'd13:   begin f.bw = 4'd12; f.bh = 4'd12; end
                default: begin f.bw = 4'd4;  f.bh = 4'd4;  end
            endcase
        end
        else f.bytes = 5'd0;
        return f;
    endfunction

    // block size splits into a power of two shift and an odd factor
    function automatic t_div_sel div_select(logic [BLK_W-1:0] b);
        t_div_sel s;
        case (b)
            4'd4:    s = '{shift: 2'd2, kind: DIV_NONE};
            4'd5:    s = '{shift: 2'd0, kind: DIV_5};
            4'd6:    s = '{shift: 2'd1, kind: DIV_3};
            4'd8:    s = '{shift: 2'd3, kind: DIV_NONE};
            4'd10:   s = '{shift: 2'd1, kind: DIV_5};
            4'd12:   s = '{shift: 2'd2, kind: DIV_3};
            default: s = '{shift: 2'd0, kind: DIV_NONE};
        endcase
        return s;
    endfunction

endpackage

// ===== sv/tmcs_front.sv =====
// ----------------------------------------------------------------------------
// tmcs_front
// accepts requests, decodes the format and builds a job for the queue
// ----------------------------------------------------------------------------
module tmcs_front #(
    parameter int MAX_MIP_LEVELS = tmcs_pkg::DEF_MAX_MIP_LEVELS
) (
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [tmcs_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                             i_q_full,
    output logic                             o_push,
    output tmcs_pkg::t_job                   o_job
);
    import tmcs_pkg::*;

    logic [FMT_W-1:0]   code;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [DEP_W-1:0]   d;
    logic [MIP_W-1:0]   mips;
    t_fmt               fmt;
    logic [MIP_W-1:0]   mips_clamped;

    assign code = i_s_axis_tdata[6:0];
    assign w    = i_s_axis_tdata[21:7];
    assign h    = i_s_axis_tdata[36:22];
    assign d    = i_s_axis_tdata[48:37];
    assign mips = i_s_axis_tdata[52:49];

    assign fmt = fmt_lookup(code);

    always_comb begin
        if (32'(mips) > MAX_MIP_LEVELS) begin
            mips_clamped = MIP_W'(MAX_MIP_LEVELS);
        end else begin
            mips_clamped = mips;
        end
    end

    assign o_s_axis_tready = !i_q_full;
    assign o_push          = i_s_axis_tvalid && !i_q_full;

    always_comb begin
        o_job.w     = w;
        o_job.h     = h;
        o_job.mips  = mips_clamped;
        o_job.bd    = BD_W'(fmt.bytes) * BD_W'(d);
        o_job.bw    = fmt.bw;
        o_job.bh    = fmt.bh;
        o_job.sel_x = div_select(fmt.bw);
        o_job.sel_y = div_select(fmt.bh);
    end

endmodule

// ===== sv/tmcs_queue.sv =====
// ----------------------------------------------------------------------------
// tmcs_queue
// short job queue between decode and the level sequencer
// ----------------------------------------------------------------------------
module tmcs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tmcs_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output tmcs_pkg::t_job  o_job
);
    import tmcs_pkg::*;

    localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0]   r_wr;
    logic [QA_W-1:0]   r_rd;
    logic [QC_W-1:0]   r_count;

    assign o_full  = (r_count == QC_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/tmcs_back.sv =====
// ----------------------------------------------------------------------------
// tmcs_back
// walks the mip levels of one job and sums the level sizes
// ----------------------------------------------------------------------------
module tmcs_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_empty,
    input  tmcs_pkg::t_job                    i_job,
    output logic                              o_pop,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [tmcs_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import tmcs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } t_state;

    t_state                    r_state;
    t_job                      r_job;
    logic [DIM_W-1:0]          r_w;
    logic [DIM_W-1:0]          r_h;
    logic [MIP_W-1:0]          r_left;
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic [DIM_W-1:0]          r_bx;
    logic [DIM_W-1:0]          r_by;
    logic [2*DIM_W-1:0]        r_area;
    logic [TOT_W-1:0]          r_lvl;
    logic [TOT_W-1:0]          r_acc;
    logic                      r_out_valid;
    logic [TOT_W-1:0]          r_total;
    logic [BLK_W-1:0]          r_bw;
    logic [BLK_W-1:0]          r_bh;

    logic [DIM_W-1:0]          n_w;
    logic [DIM_W-1:0]          n_h;
    logic [2*DIM_W+BD_W-1:0]   lvl_full;
    logic                      out_free;
    logic                      flush_done;

    // ceil(n / b) with the divide done by shift and reciprocal multiply
    function automatic logic [DIM_W-1:0] blocks_of(logic [DIM_W-1:0] n,
                                                   logic [BLK_W-1:0] b,
                                                   t_div_sel         sel);
        logic [DIM_W:0]            x;
        logic [DIM_W:0]            xs;
        logic [DIM_W+DIV3_SH:0]    p3;
        logic [DIM_W+DIV5_SH:0]    p5;
        logic [DIM_W-1:0]          q;
        x  = (DIM_W+1)'(n) + (DIM_W+1)'(b) - (DIM_W+1)'(1);
        xs = x >> sel.shift;
        p3 = (DIM_W+DIV3_SH+1)'(xs) * (DIM_W+DIV3_SH+1)'(DIV3_MUL);
        p5 = (DIM_W+DIV5_SH+1)'(xs) * (DIM_W+DIV5_SH+1)'(DIV5_MUL);
        unique case (sel.kind)
            DIV_3:    q = p3[DIV3_SH +: DIM_W];
            DIV_5:    q = p5[DIV5_SH +: DIM_W];
            DIV_NONE: q = xs[DIM_W-1:0];
            default:  q = xs[DIM_W-1:0];
        endcase
        return q;
    endfunction

    assign n_w      = (r_w[DIM_W-1:1] == '0) ? DIM_W'(1) : DIM_W'(r_w >> 1);
    assign n_h      = (r_h[DIM_W-1:1] == '0) ? DIM_W'(1) : DIM_W'(r_h >> 1);
    assign lvl_full = (2*DIM_W+BD_W)'(r_area) * (2*DIM_W+BD_W)'(r_job.bd);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty;

    assign flush_done = (r_state == ST_FLUSH) && !r_v1 && !r_v2 && !r_v3 && out_free;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_bh, r_bw, r_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1   <= (r_state == ST_RUN) && (r_left != '0);
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_area <= (2*DIM_W)'(r_bx) * (2*DIM_W)'(r_by);
            r_lvl  <= lvl_full[TOT_W-1:0];
            if (r_v3) begin
                r_acc <= r_acc + r_lvl;
            end
            if (flush_done) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_job   <= i_job;
                        r_w     <= i_job.w;
                        r_h     <= i_job.h;
                        r_left  <= i_job.mips;
                        r_acc   <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_left != '0) begin
                        r_bx   <= blocks_of(r_w, r_job.bw, r_job.sel_x);
                        r_by   <= blocks_of(r_h, r_job.bh, r_job.sel_y);
                        r_w    <= n_w;
                        r_h    <= n_h;
                        r_left <= r_left - 1'b1;
                    end else begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    if (flush_done) begin
                        r_total     <= r_acc;
                        r_bw        <= r_job.bw;
                        r_bh        <= r_job.bh;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/texture_mip_chain_size.sv =====
// ----------------------------------------------------------------------------
// texture_mip_chain_size
// byte size of a texture mip chain with the format's block dimensions
//
//   channel   dir  tdata fields (lsb first)
//   s_axis    in   format_code[6:0] width_px[21:7] height_px[36:22]
//                  depth_px[48:37] mip_count[52:49]
//   m_axis    out  total_bytes[31:0] block_width[35:32] block_height[39:36]
//
// the level sequencer takes one item at a time from the queue and holds it
// until its result is registered; a stalled output holds it in flush
// the sequencer issues one mip level per cycle into a three stage
// divide and multiply pipe, then drains it before the result is registered
// the job queue holds two decoded items, so input is taken while one runs
// reset is synchronous and active low; the queue and output register clear
// ----------------------------------------------------------------------------
module texture_mip_chain_size #(
    parameter int MAX_MIP_LEVELS = tmcs_pkg::DEF_MAX_MIP_LEVELS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // format_code, width_px, height_px, depth_px, mip_count
    input  logic [tmcs_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // total_bytes, block_width, block_height
    output logic [tmcs_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import tmcs_pkg::*;

`include "texture_mip_chain_size_defines.svh"

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    t_job  push_job;
    t_job  head_job;

    tmcs_front #(
        .MAX_MIP_LEVELS (MAX_MIP_LEVELS)
    ) u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_job           (push_job)
    );

    tmcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    tmcs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_job           (head_job),
        .o_pop           (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    `TMCS_ASSERT_CLK(a_no_push_when_full, q_push |-> !q_full)
    `TMCS_ASSERT_CLK(a_no_pop_when_empty, q_pop |-> !q_empty)
    `TMCS_ASSERT_CLK(a_one_item_at_a_time, q_pop |=> !q_pop)
    `TMCS_ASSERT_RST(a_out_idle_after_reset, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

// ===== dv/texture_mip_chain_size_test.sv =====
// ----------------------------------------------------------------------------
// texture_mip_chain_size_test
// self-checking bench for the mip chain size block: requests go in on the
// slave stream, each result is checked field by field against a local model
// of the format table and the level loop, under random gaps and stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module texture_mip_chain_size_test;

    localparam int  LEVEL_CAP   = tmcs_pkg::DEF_MAX_MIP_LEVELS;
    localparam int  CYCLE_LIMIT = 500000;
    localparam int  TAIL_CYCLES = 64;
    localparam int  FMT_SLOTS   = 128;
    localparam int  ASTC_LINEAR = 87;
    localparam int  ASTC_SRGB   = 101;
    localparam int  ASTC_SIZES  = 14;
    // astc block sizes, entry i in bits [4*i+3:4*i]
    localparam logic [55:0] ASTC_BW = 56'hCCAAAA88866554;
    localparam logic [55:0] ASTC_BH = 56'hCAA86586565544;

    typedef struct {
        logic [tmcs_pkg::FMT_W-1:0] code;
        logic [tmcs_pkg::DIM_W-1:0] w;
        logic [tmcs_pkg::DIM_W-1:0] h;
        logic [tmcs_pkg::DEP_W-1:0] d;
        logic [tmcs_pkg::MIP_W-1:0] mips;
    } t_size_req;

    typedef struct {
        logic [tmcs_pkg::TOT_W-1:0] total;
        logic [tmcs_pkg::BLK_W-1:0] bw;
        logic [tmcs_pkg::BLK_W-1:0] bh;
    } t_size_res;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_s_axis_tvalid = 1'b0;
    logic                               o_s_axis_tready;
    // format_code, width_px, height_px, depth_px, mip_count
    logic [tmcs_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata = '0;
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready = 1'b0;
    // total_bytes, block_width, block_height
    logic [tmcs_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata;

    logic [4:0]                 fmt_bytes [FMT_SLOTS];
    logic [3:0]                 fmt_bw    [FMT_SLOTS];
    logic [3:0]                 fmt_bh    [FMT_SLOTS];
    t_size_res                  pending_sizes [$];

    int errors       = 0;
    int cycles       = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_compressed = 0;
    int n_unknown    = 0;
    int stall_pct    = 0;
    int stall_run    = 1;
    int stall_left   = 0;
    logic stall_ready = 1'b1;

    texture_mip_chain_size u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_sizes.size());
            $display("status: fail");
            $finish;
        end
    end

    // receiver stall pattern: runs of ready and not ready of random length
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left  = $urandom_range(1, stall_run);
            stall_ready = ($urandom_range(0, 99) >= stall_pct);
        end else begin
            stall_left--;
        end
        i_m_axis_tready <= stall_ready;
    end

    task automatic fill_formats(input int lo, input int hi, input int bytes,
                                input int bw, input int bh);
        for (int c = lo; c <= hi; c++) begin
            fmt_bytes[c] = 5'(bytes);
            fmt_bw[c]    = 4'(bw);
            fmt_bh[c]    = 4'(bh);
        end
    endtask

    function automatic t_size_res chain_bytes(t_size_req r);
        t_size_res   res;
        logic [63:0] w;
        logic [63:0] h;
        logic [63:0] bw;
        logic [63:0] bh;
        logic [63:0] lvl;
        int          levels;
        w         = 64'(r.w);
        h         = 64'(r.h);
        bw        = 64'(fmt_bw[r.code]);
        bh        = 64'(fmt_bh[r.code]);
        res.bw    = fmt_bw[r.code];
        res.bh    = fmt_bh[r.code];
        res.total = '0;
        levels    = (r.mips > LEVEL_CAP) ? LEVEL_CAP : int'(r.mips);
        for (int i = 0; i < levels; i++) begin
            lvl = ((w + bw - 1) / bw) * ((h + bh - 1) / bh)
                  * 64'(fmt_bytes[r.code]) * 64'(r.d);
            res.total = res.total + lvl[31:0];
            w = (w >> 1 == 0) ? 64'd1 : w >> 1;
            h = (h >> 1 == 0) ? 64'd1 : h >> 1;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what,
                 got, want);
        errors++;
    endtask

    task automatic send_request(input t_size_req r);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, r.mips, r.d, r.h, r.w, r.code};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_sizes.push_back(chain_bytes(r));
        n_sent++;
        if (fmt_bw[r.code] != 1 || fmt_bh[r.code] != 1) n_compressed++;
        if (fmt_bytes[r.code] == 0) n_unknown++;
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= 56'({$urandom, $urandom});
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        idle_sender(1);
        while (pending_sizes.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_fields(input int code, input int w, input int h, input int d,
                               input int mips);
        t_size_req r;
        r.code = 7'(code);
        r.w    = 15'(w);
        r.h    = 15'(h);
        r.d    = 12'(d);
        r.mips = 4'(mips);
        send_request(r);
    endtask

    function automatic logic [14:0] random_dim();
        case ($urandom_range(0, 9))
            5, 6:    return 15'(1 << $urandom_range(0, 14));
            7:       return 15'($urandom_range(0, 32767));
            8:       return 15'($urandom_range(1, 16384));
            9:       return 15'($urandom_range(0, 3));
            default: return 15'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic t_size_req random_request();
        t_size_req r;
        r.code = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(115, 127)
                                                : $urandom_range(0, 114));
        r.w    = random_dim();
        r.h    = random_dim();
        case ($urandom_range(0, 9))
            0, 1:    r.d = 12'($urandom_range(1, 2048));
            2:       r.d = 12'($urandom_range(0, 4095));
            default: r.d = 12'($urandom_range(1, 8));
        endcase
        r.mips = 4'($urandom_range(0, 15));
        return r;
    endfunction

    // bursts of random length, random gaps, a full drain every drain_every items
    task automatic run_traffic(input int n, input int gap_max, input int drain_every);
        int left;
        int burst;
        left = n;
        while (left > 0) begin
            burst = (gap_max == 0) ? left : $urandom_range(1, 12);
            if (burst > left) burst = left;
            repeat (burst) begin
                send_request(random_request());
                left--;
                if (drain_every > 0 && left % drain_every == 0) wait_drained();
            end
            if (gap_max > 0) idle_sender($urandom_range(0, gap_max));
        end
    endtask

    task automatic test_format_corners();
        stall_pct = 20;
        stall_run = 3;
        send_fields(0, 64, 64, 1, 7);
        send_fields(1, 1, 1, 1, 1);
        send_fields(55, 33, 17, 3, 6);
        send_fields(64, 7, 5, 1, 4);
        send_fields(66, 9, 9, 2, 4);
        send_fields(76, 13, 3, 1, 5);
        send_fields(81, 17, 9, 1, 6);
        send_fields(114, 13, 13, 1, 3);
        send_fields(115, 100, 100, 1, 5);
        send_fields(127, 32767, 32767, 4095, 15);
        wait_drained();
    endtask

    task automatic test_size_corners();
        stall_pct = 0;
        send_fields(12, 0, 0, 1, 4);
        send_fields(100, 0, 25, 5, 3);
        send_fields(44, 32767, 32767, 4095, 15);
        send_fields(46, 16384, 16384, 2048, 15);
        send_fields(33, 50, 50, 0, 9);
        send_fields(90, 1, 16384, 4095, 15);
        send_fields(70, 16384, 1, 1, 15);
        wait_drained();
    endtask

    task automatic test_mip_counts();
        stall_pct = 50;
        stall_run = 5;
        send_fields(113, 300, 200, 2, 0);
        send_fields(85, 31, 31, 1, 1);
        send_fields(35, 1000, 700, 6, 15);
        send_fields(58, 1023, 513, 3, 15);
        send_fields(20, 5, 3, 1, 15);
        wait_drained();
    endtask

    task automatic test_bursts();
        stall_pct = 30;
        stall_run = 6;
        run_traffic(1300, 10, 250);
    endtask

    task automatic test_streaming();
        stall_pct = 0;
        run_traffic(350, 0, 0);
    endtask

    task automatic test_backpressure();
        stall_pct = 75;
        stall_run = 16;
        run_traffic(300, 4, 100);
    endtask

    always @(posedge i_clk) begin
        t_size_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_sizes.size() == 0) begin
                report_mismatch("result with nothing pending", o_m_axis_tdata[31:0],
                                32'd0);
            end else begin
                want = pending_sizes.pop_front();
                n_checked++;
                if (o_m_axis_tdata[31:0] !== want.total)
                    report_mismatch("total_bytes", o_m_axis_tdata[31:0], want.total);
                if (o_m_axis_tdata[35:32] !== want.bw)
                    report_mismatch("block_width", 32'(o_m_axis_tdata[35:32]),
                                    32'(want.bw));
                if (o_m_axis_tdata[39:36] !== want.bh)
                    report_mismatch("block_height", 32'(o_m_axis_tdata[39:36]),
                                    32'(want.bh));
            end
        end
    end

    initial begin
        fill_formats(0, FMT_SLOTS - 1, 0, 1, 1);
        fill_formats(1, 7, 1, 1, 1);
        fill_formats(8, 10, 2, 1, 1);
        fill_formats(11, 13, 4, 1, 1);
        fill_formats(14, 17, 2, 1, 1);
        fill_formats(18, 20, 4, 1, 1);
        fill_formats(21, 23, 8, 1, 1);
        fill_formats(24, 28, 3, 1, 1);
        fill_formats(29, 31, 6, 1, 1);
        fill_formats(32, 34, 12, 1, 1);
        fill_formats(35, 40, 4, 1, 1);
        fill_formats(41, 43, 8, 1, 1);
        fill_formats(44, 46, 16, 1, 1);
        fill_formats(47, 47, 2, 1, 1);
        fill_formats(48, 48, 4, 1, 1);
        fill_formats(49, 53, 2, 1, 1);
        fill_formats(54, 54, 4, 1, 1);
        fill_formats(55, 55, 5, 1, 1);
        // bc1 to bc7
        fill_formats(56, 59, 8, 4, 4);
        fill_formats(60, 63, 16, 4, 4);
        fill_formats(64, 65, 8, 4, 4);
        fill_formats(66, 71, 16, 4, 4);
        // etc and eac
        fill_formats(72, 78, 8, 4, 4);
        fill_formats(79, 80, 16, 4, 4);
        // pvrtc
        fill_formats(81, 82, 8, 8, 4);
        fill_formats(83, 84, 8, 4, 4);
        fill_formats(85, 85, 8, 8, 4);
        fill_formats(86, 86, 8, 4, 4);
        for (int i = 0; i < ASTC_SIZES; i++) begin
            fill_formats(ASTC_LINEAR + i, ASTC_LINEAR + i, 16,
                         int'(ASTC_BW[4*i +: 4]), int'(ASTC_BH[4*i +: 4]));
            fill_formats(ASTC_SRGB + i, ASTC_SRGB + i, 16,
                         int'(ASTC_BW[4*i +: 4]), int'(ASTC_BH[4*i +: 4]));
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_format_corners();
        test_size_corners();
        test_mip_counts();
        test_bursts();
        test_streaming();
        test_backpressure();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_sizes.size() != 0)
            report_mismatch("results never returned", 32'(pending_sizes.size()), 32'd0);

        $display("sent %0d size requests (%0d block compressed, %0d with no byte count)",
                 n_sent, n_compressed, n_unknown);
        $display("checked %0d results over %0d cycles, %0d mismatches",
                 n_checked, cycles, errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tmcs_pkg.sv
sv/tmcs_front.sv
sv/tmcs_queue.sv
sv/tmcs_back.sv
sv/texture_mip_chain_size.sv
dv/texture_mip_chain_size_test.sv
